// File: rtl/assert_macros.svh
// Assertion helpers used by the coalescer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define RGEC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define RGEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent
`define RGEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/rgec_pkg.sv
`timescale 1ns / 1ps
package rgec_pkg;

  localparam int unsigned OFF_W     = 22;
  localparam int unsigned LEN_W     = 23;
  localparam int unsigned GAP_CNT_W = 9;
  localparam int unsigned LIMIT_W   = 8;

  localparam longint CONTAINER_BYTES = 4194304;
  localparam longint LEN_MAX_VAL     = (64'd1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_CAP =
    LEN_W'(CONTAINER_BYTES < LEN_MAX_VAL ? CONTAINER_BYTES : LEN_MAX_VAL);

  localparam logic [GAP_CNT_W-1:0] GAP_CNT_MAX = {GAP_CNT_W{1'b1}};

  // Output queue geometry
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;
  localparam int unsigned OQ_CNT_W = 3;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             needed;
    logic             last;
  } rgec_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] ext_offset;
    logic [LEN_W-1:0] ext_length;
    logic [LEN_W-1:0] buf_offset;
    logic             ext_last;
  } rgec_result_t;

  typedef struct packed {
    logic ext_open;
    logic gap_pending;
  } rgec_status_t;

  // Byte sum that saturates at the container bound
  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LEN_CAP}) ? LEN_CAP : s[LEN_W-1:0];
  endfunction

endpackage

// File: rtl/gap_filled_read_extent_coalescer_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Read extent coalescer: takes one chunk metadata entry per cycle and turns
// runs of needed entries (bridging short unneeded gaps up to gap_limit) into
// read extents with a running destination offset. An accepted entry is held
// in an input register, merged into the extent state by a single
// add-and-compare step, and its zero, one or two results are pushed into a
// four-entry output queue. Throughput is one entry per cycle whenever the
// queue has room for two results, so a sink that stalls only throttles the
// input once that queue holds three or more extents. Write gap_limit only
// while idle.
module gap_filled_read_extent_coalescer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rgec_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rgec_pkg::OFF_W-1:0]   in_entry_offset,
  input  logic [rgec_pkg::LEN_W-1:0]   in_entry_length,
  input  logic                         in_needed,
  input  logic                         in_last_entry,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rgec_pkg::OFF_W-1:0]   out_extent_offset,
  output logic [rgec_pkg::LEN_W-1:0]   out_extent_length,
  output logic [rgec_pkg::LEN_W-1:0]   out_buffer_offset,
  output logic                         out_extent_last
);

  logic                          stg_v_r, stg_v_nxt;
  rgec_pkg::rgec_item_t          stg_item_r;
  logic                          in_fire, stg_fire, room2;
  logic                          res0_valid, res1_valid;
  rgec_pkg::rgec_result_t        res0, res1, head;
  rgec_pkg::rgec_status_t        status;
  logic [rgec_pkg::OQ_CNT_W-1:0] oq_count;

  // Move the staged entry on when the queue can take two results
  assign stg_fire  = stg_v_r & room2;
  assign in_ready  = ~stg_v_r | room2;
  assign in_fire   = in_valid & in_ready;
  assign stg_v_nxt = in_fire | (stg_v_r & ~stg_fire);

  // Hold the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_item_r <= '{offset: in_entry_offset, length: in_entry_length,
                      needed: in_needed, last: in_last_entry};
    end
  end

  rgec_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_fire   (stg_fire),
    .item        (stg_item_r),
    .res0_valid  (res0_valid),
    .res1_valid  (res1_valid),
    .res0        (res0),
    .res1        (res1),
    .status      (status)
  );

  rgec_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0_valid),
    .push1     (res1_valid),
    .din0      (res0),
    .din1      (res1),
    .pop       (out_valid & out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2),
    .count     (oq_count)
  );

  assign out_extent_offset = head.ext_offset;
  assign out_extent_length = head.ext_length;
  assign out_buffer_offset = head.buf_offset;
  assign out_extent_last   = head.ext_last;

  // Queue never overfills
  `RGEC_ASSERT_ALWAYS(a_oq_bound, clk, rst_n, oq_count <= rgec_pkg::OQ_CNT_W'(rgec_pkg::OQ_DEPTH), "output queue overflow")
  // A second result only follows a first, and always ends the list
  `RGEC_ASSERT_SAME(a_res1_last, clk, rst_n, res1_valid, res0_valid && res1.ext_last && !res0.ext_last, "bad second result")
  // The end of a list drops all extent and gap state
  `RGEC_ASSERT_NEXT(a_list_clear, clk, rst_n, stg_fire && stg_item_r.last, !status.ext_open && !status.gap_pending, "list state not cleared")
  // Every list end yields a final result
  `RGEC_ASSERT_SAME(a_last_emits, clk, rst_n, stg_fire && stg_item_r.last, res0_valid, "missing final extent")

endmodule

// File: rtl/rgec_merge.sv
`timescale 1ns / 1ps
module rgec_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rgec_pkg::LIMIT_W-1:0] cfg_wr_data,
  input  logic                         item_fire,
  input  rgec_pkg::rgec_item_t         item,
  output logic                         res0_valid,
  output logic                         res1_valid,
  output rgec_pkg::rgec_result_t       res0,
  output rgec_pkg::rgec_result_t       res1,
  output rgec_pkg::rgec_status_t       status
);

  logic [rgec_pkg::LIMIT_W-1:0]   gap_limit_r;
  logic                           ext_open_r,  ext_open_nxt;
  logic [rgec_pkg::OFF_W-1:0]     ext_start_r, ext_start_nxt;
  logic [rgec_pkg::LEN_W-1:0]     ext_bytes_r, ext_bytes_nxt;
  logic [rgec_pkg::GAP_CNT_W-1:0] gap_cnt_r,   gap_cnt_nxt;
  logic [rgec_pkg::LEN_W-1:0]     gap_bytes_r, gap_bytes_nxt;
  logic [rgec_pkg::OFF_W-1:0]     gap_start_r, gap_start_nxt;
  logic [rgec_pkg::LEN_W-1:0]     dest_r,      dest_nxt;

  logic [rgec_pkg::LEN_W-1:0] len;
  logic [rgec_pkg::LEN_W-1:0] base_bytes;
  logic [rgec_pkg::LEN_W-1:0] gap_base;
  logic                       short_gap;

  // Hold the gap limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= '0;
    end else if (cfg_wr_en) begin
      gap_limit_r <= cfg_wr_data;
    end
  end

  // Update the running extent and gap for one entry
  always_comb begin
    len = (item.length > rgec_pkg::LEN_CAP) ? rgec_pkg::LEN_CAP : item.length;
    short_gap = (gap_cnt_r != '0) &&
                (gap_cnt_r <= {{(rgec_pkg::GAP_CNT_W-rgec_pkg::LIMIT_W){1'b0}}, gap_limit_r});
    base_bytes = ext_open_r ? rgec_pkg::sat_add(ext_bytes_r, gap_bytes_r) : gap_bytes_r;
    gap_base   = (gap_cnt_r == '0) ? '0 : gap_bytes_r;

    ext_open_nxt  = ext_open_r;
    ext_start_nxt = ext_start_r;
    ext_bytes_nxt = ext_bytes_r;
    gap_cnt_nxt   = gap_cnt_r;
    gap_bytes_nxt = gap_bytes_r;
    gap_start_nxt = gap_start_r;
    dest_nxt      = dest_r;
    res0_valid    = 1'b0;
    res1_valid    = 1'b0;
    res0          = '0;
    res1          = '0;

    if (item_fire) begin
      if (item.needed) begin
        if (short_gap) begin
          // Read through the short gap
          ext_open_nxt  = 1'b1;
          ext_start_nxt = ext_open_r ? ext_start_r : gap_start_r;
          ext_bytes_nxt = rgec_pkg::sat_add(base_bytes, len);
        end else if (ext_open_r && (gap_cnt_r != '0)) begin
          // Gap too long: close the held extent, open a new one here
          res0_valid    = 1'b1;
          res0          = '{ext_offset: ext_start_r, ext_length: ext_bytes_r,
                            buf_offset: dest_r, ext_last: 1'b0};
          dest_nxt      = rgec_pkg::sat_add(dest_r, ext_bytes_r);
          ext_start_nxt = item.offset;
          ext_bytes_nxt = len;
        end else if (ext_open_r) begin
          ext_bytes_nxt = rgec_pkg::sat_add(ext_bytes_r, len);
        end else begin
          ext_open_nxt  = 1'b1;
          ext_start_nxt = item.offset;
          ext_bytes_nxt = len;
        end
        gap_cnt_nxt   = '0;
        gap_bytes_nxt = '0;
      end else begin
        // Extend the pending gap
        if (gap_cnt_r == '0) begin
          gap_start_nxt = item.offset;
        end
        if (gap_cnt_r != rgec_pkg::GAP_CNT_MAX) begin
          gap_cnt_nxt = gap_cnt_r + 1'b1;
        end
        gap_bytes_nxt = rgec_pkg::sat_add(gap_base, len);
      end

      if (item.last) begin
        // Emit the final extent and drop all list state
        if (res0_valid) begin
          res1_valid = 1'b1;
          res1 = '{ext_offset: ext_start_nxt, ext_length: ext_bytes_nxt,
                   buf_offset: dest_nxt, ext_last: 1'b1};
        end else begin
          res0_valid = 1'b1;
          res0 = '{ext_offset: ext_open_nxt ? ext_start_nxt : '0,
                   ext_length: ext_open_nxt ? ext_bytes_nxt : '0,
                   buf_offset: dest_nxt, ext_last: 1'b1};
        end
        ext_open_nxt  = 1'b0;
        ext_start_nxt = '0;
        ext_bytes_nxt = '0;
        gap_cnt_nxt   = '0;
        gap_bytes_nxt = '0;
        gap_start_nxt = '0;
        dest_nxt      = '0;
      end
    end
  end

  // Advance the list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_open_r  <= 1'b0;
      ext_start_r <= '0;
      ext_bytes_r <= '0;
      gap_cnt_r   <= '0;
      gap_bytes_r <= '0;
      gap_start_r <= '0;
      dest_r      <= '0;
    end else begin
      ext_open_r  <= ext_open_nxt;
      ext_start_r <= ext_start_nxt;
      ext_bytes_r <= ext_bytes_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
      gap_bytes_r <= gap_bytes_nxt;
      gap_start_r <= gap_start_nxt;
      dest_r      <= dest_nxt;
    end
  end

  assign status = '{ext_open: ext_open_r, gap_pending: (gap_cnt_r != '0)};

endmodule

// File: rtl/rgec_outq.sv
`timescale 1ns / 1ps
module rgec_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push0,
  input  logic                          push1,
  input  rgec_pkg::rgec_result_t        din0,
  input  rgec_pkg::rgec_result_t        din1,
  input  logic                          pop,
  output rgec_pkg::rgec_result_t        head,
  output logic                          not_empty,
  output logic                          room2,
  output logic [rgec_pkg::OQ_CNT_W-1:0] count
);

  rgec_pkg::rgec_result_t mem_r [rgec_pkg::OQ_DEPTH];

  logic [rgec_pkg::OQ_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rgec_pkg::OQ_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rgec_pkg::OQ_CNT_W-1:0] cnt_r,    cnt_nxt;
  logic [rgec_pkg::OQ_AW-1:0]    wr_ptr_p1;

  // Compute pointer and fill updates
  always_comb begin
    wr_ptr_p1  = wr_ptr_r + 1'b1;
    wr_ptr_nxt = wr_ptr_r + rgec_pkg::OQ_AW'(push0) + rgec_pkg::OQ_AW'(push1);
    rd_ptr_nxt = rd_ptr_r + rgec_pkg::OQ_AW'(pop);
    cnt_nxt    = cnt_r + rgec_pkg::OQ_CNT_W'(push0) + rgec_pkg::OQ_CNT_W'(push1)
                 - rgec_pkg::OQ_CNT_W'(pop);
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_ptr_r] <= din0;
    end
    if (push1) begin
      mem_r[wr_ptr_p1] <= din1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= rgec_pkg::OQ_CNT_W'(rgec_pkg::OQ_DEPTH - 2));
  assign count     = cnt_r;

endmodule
